// ----- hw/rtl/crs_pkg.sv -----
`default_nettype none

package crs_pkg;

	// fixed point setup of phase and ratio
	localparam int FRAC_BITS = 12;
	localparam int IP_BITS   = (FRAC_BITS > 12) ? 12 : FRAC_BITS;
	localparam int SAMPLE_W  = 16;
	localparam int RATIO_W   = 15;
	localparam int PHASE_W   = FRAC_BITS + 3;
	localparam int FILL_W    = 3;

	localparam int PH_ONE_I = 1 << FRAC_BITS;
	localparam logic [PHASE_W-1:0] PH_ONE    = PHASE_W'(PH_ONE_I);
	localparam logic [PHASE_W-1:0] RATIO_MIN = PHASE_W'(PH_ONE_I >> 2);
	localparam logic [PHASE_W-1:0] RATIO_MAX = PHASE_W'(PH_ONE_I << 2);
	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(4096);
	localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(4);

	// Horner datapath widths
	localparam int COEF_W    = 22;
	localparam int ACC_W     = 3 * IP_BITS + 22;
	localparam int LO_W      = 30;
	localparam int HI_W      = ACC_W - LO_W;
	localparam int MUL_A_W   = LO_W + 1;
	localparam int MUL_B_W   = IP_BITS + 1;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int DIV_SHIFT = 3 * IP_BITS + 1;
	localparam int QUO_W     = ACC_W - DIV_SHIFT;

	localparam int HORNER_W = 2;
	localparam logic [HORNER_W-1:0] HORNER_K2 = 2'd0;
	localparam logic [HORNER_W-1:0] HORNER_K1 = 2'd1;
	localparam logic [HORNER_W-1:0] HORNER_Y1 = 2'd2;

	localparam logic signed [QUO_W-1:0] QUO_MAX = QUO_W'(32767);
	localparam logic signed [QUO_W-1:0] QUO_MIN = QUO_W'(-32768);

	function automatic logic [PHASE_W-1:0] clamp_ratio(input logic [RATIO_W-1:0] ratio);
		logic [31:0] r;
		r = 32'(ratio);
		if (r < 32'(RATIO_MIN)) begin
			r = 32'(RATIO_MIN);
		end else if (r > 32'(RATIO_MAX)) begin
			r = 32'(RATIO_MAX);
		end
		return PHASE_W'(r);
	endfunction

	function automatic logic is_unity(input logic [RATIO_W-1:0] ratio);
		return 32'(ratio) == 32'(PH_ONE_I);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cubic_pitch_resampler.sv -----
`default_nettype none

// Cubic pitch resampler: signed 16-bit audio in, resampled audio out.
// Input channel: in_valid / in_stall / in_sample; an item is taken when
//   in_valid is high and in_stall is low. in_stall is high while an item
//   is being worked on.
// Output channel: out_valid / out_stall / out_sample / last_of_run; zero
//   to four items per input item, last_of_run marks the final one.
// Config: pitch_ratio (12 fraction bits) is written when cfg_wr_en is high;
//   write only while idle. Values outside 0.25..4.0 are clamped.
// Sequence: an accept step, a coefficient step, then per result three
//   Horner steps (each a low and a high multiply on one shared 31x13
//   multiplier) and a round/saturate/emit step. An item gives at most
//   four results. Ratio exactly 1.0 is a straight pass-through with one
//   result.
// Unless the ratio is exactly 1.0, the first three items after reset prime
//   the four-sample history and give no result.
// Reset: history cleared, phase = 1.0, ratio = 1.0, output empty.
// Output stall: the result sits in the output register; the sequencer
//   waits in its emit step until the register frees up, nothing is lost.
module cubic_pitch_resampler (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [crs_pkg::SAMPLE_W-1:0]  in_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [crs_pkg::SAMPLE_W-1:0]       out_sample,
	output logic                                      last_of_run,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [crs_pkg::RATIO_W-1:0]          pitch_ratio
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_COEF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [crs_pkg::RATIO_W-1:0]              pitch_ratio_q;
	logic signed [crs_pkg::SAMPLE_W-1:0]      hist_q [4];
	logic [crs_pkg::FILL_W-1:0]               fill_q;
	logic [crs_pkg::PHASE_W-1:0]              phase_q;
	logic [crs_pkg::PHASE_W-1:0]              step_q;
	logic signed [crs_pkg::COEF_W-1:0]        k1_q, k2_q, k3_q;
	logic signed [crs_pkg::ACC_W-1:0]         acc_q;
	logic signed [crs_pkg::PROD_W-1:0]        prod_lo_q;
	logic [crs_pkg::HORNER_W-1:0]             idx_q;
	logic                                     out_valid_q;
	logic signed [crs_pkg::SAMPLE_W-1:0]      out_sample_q;
	logic                                     last_of_run_q;

	// handshake
	logic in_take, out_free, out_load;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && (state_q == ST_EMIT || state_q == ST_PASS);
	assign out_valid   = out_valid_q;
	assign out_sample  = out_sample_q;
	assign last_of_run = last_of_run_q;

	// phase bookkeeping
	logic [crs_pkg::FILL_W-1:0]  fill_nxt;
	logic [crs_pkg::PHASE_W-1:0] phase_sub, phase_sum;
	logic                        emit_last;
	logic [crs_pkg::IP_BITS-1:0] frac;

	assign fill_nxt  = (fill_q < crs_pkg::FILL_FULL) ? fill_q + crs_pkg::FILL_W'(1) : fill_q;
	assign phase_sub = (phase_q >= crs_pkg::PH_ONE) ? phase_q - crs_pkg::PH_ONE : '0;
	assign phase_sum = phase_q + step_q;
	assign emit_last = (phase_sum >= crs_pkg::PH_ONE);
	assign frac      = phase_q[crs_pkg::FRAC_BITS-1 -: crs_pkg::IP_BITS];

	// cubic coefficients from the shifted history (y3 newest)
	logic signed [crs_pkg::COEF_W-1:0] y0, y1, y2, y3, d12;
	logic signed [crs_pkg::COEF_W-1:0] k1_c, k2_c, k3_c;
	assign y0   = crs_pkg::COEF_W'(hist_q[0]);
	assign y1   = crs_pkg::COEF_W'(hist_q[1]);
	assign y2   = crs_pkg::COEF_W'(hist_q[2]);
	assign y3   = crs_pkg::COEF_W'(hist_q[3]);
	assign d12  = y1 - y2;
	assign k1_c = y2 - y0;
	assign k2_c = (y0 <<< 1) - ((y1 <<< 2) + y1) + (y2 <<< 2) - y3;
	assign k3_c = y3 - y0 + (d12 <<< 1) + d12;

	// shared multiplier: accumulator split in a low unsigned and a high signed half
	logic signed [crs_pkg::MUL_A_W-1:0] mul_a;
	logic signed [crs_pkg::MUL_B_W-1:0] mul_b;
	logic signed [crs_pkg::PROD_W-1:0]  mul_prod;
	assign mul_a = (state_q == ST_MUL_HI) ?
		crs_pkg::MUL_A_W'($signed(acc_q[crs_pkg::ACC_W-1:crs_pkg::LO_W])) :
		$signed({1'b0, acc_q[crs_pkg::LO_W-1:0]});
	assign mul_b    = $signed({1'b0, frac});
	assign mul_prod = mul_a * mul_b;

	logic signed [crs_pkg::ACC_W-1:0] addend, acc_next;
	always_comb begin
		case (idx_q)
			crs_pkg::HORNER_K2: addend = crs_pkg::ACC_W'(k2_q) <<< crs_pkg::IP_BITS;
			crs_pkg::HORNER_K1: addend = crs_pkg::ACC_W'(k1_q) <<< (2 * crs_pkg::IP_BITS);
			default:            addend = crs_pkg::ACC_W'(hist_q[1]) <<< crs_pkg::DIV_SHIFT;
		endcase
	end
	assign acc_next = (crs_pkg::ACC_W'(mul_prod) <<< crs_pkg::LO_W)
		+ crs_pkg::ACC_W'(prod_lo_q) + addend;

	// divide by 2*U^3, truncating toward zero, then saturate
	logic signed [crs_pkg::ACC_W-1:0]    bias, biased;
	logic signed [crs_pkg::QUO_W-1:0]    quo;
	logic signed [crs_pkg::SAMPLE_W-1:0] result;
	assign bias   = acc_q[crs_pkg::ACC_W-1] ?
		$signed({{(crs_pkg::ACC_W - crs_pkg::DIV_SHIFT){1'b0}}, {crs_pkg::DIV_SHIFT{1'b1}}}) : '0;
	assign biased = acc_q + bias;
	assign quo    = crs_pkg::QUO_W'(biased >>> crs_pkg::DIV_SHIFT);
	always_comb begin
		if (quo > crs_pkg::QUO_MAX) begin
			result = crs_pkg::SAMPLE_W'(crs_pkg::QUO_MAX);
		end else if (quo < crs_pkg::QUO_MIN) begin
			result = crs_pkg::SAMPLE_W'(crs_pkg::QUO_MIN);
		end else begin
			result = crs_pkg::SAMPLE_W'(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pitch_ratio_q <= crs_pkg::RATIO_RESET;
			for (int i = 0; i < 4; i++) hist_q[i] <= '0;
			fill_q        <= '0;
			phase_q       <= crs_pkg::PH_ONE;
			step_q        <= crs_pkg::PH_ONE;
			k1_q          <= '0;
			k2_q          <= '0;
			k3_q          <= '0;
			acc_q         <= '0;
			prod_lo_q     <= '0;
			idx_q         <= crs_pkg::HORNER_K2;
			out_valid_q   <= 1'b0;
			out_sample_q  <= '0;
			last_of_run_q <= 1'b0;
		end else begin
			if (cfg_wr_en) pitch_ratio_q <= pitch_ratio;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						hist_q[0] <= hist_q[1];
						hist_q[1] <= hist_q[2];
						hist_q[2] <= hist_q[3];
						hist_q[3] <= in_sample;
						fill_q    <= fill_nxt;
						if (crs_pkg::is_unity(pitch_ratio_q)) begin
							state_q <= ST_PASS;
						end else if (fill_nxt == crs_pkg::FILL_FULL) begin
							phase_q <= phase_sub;
							step_q  <= crs_pkg::clamp_ratio(pitch_ratio_q);
							if (phase_sub < crs_pkg::PH_ONE) state_q <= ST_COEF;
						end
					end
				end
				ST_PASS: begin
					if (out_free) begin
						out_sample_q  <= hist_q[3];
						last_of_run_q <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_COEF: begin
					k1_q    <= k1_c;
					k2_q    <= k2_c;
					k3_q    <= k3_c;
					acc_q   <= crs_pkg::ACC_W'(k3_c);
					idx_q   <= crs_pkg::HORNER_K2;
					state_q <= ST_MUL_LO;
				end
				ST_MUL_LO: begin
					prod_lo_q <= mul_prod;
					state_q   <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					acc_q <= acc_next;
					if (idx_q == crs_pkg::HORNER_Y1) begin
						state_q <= ST_EMIT;
					end else begin
						idx_q   <= idx_q + crs_pkg::HORNER_W'(1);
						state_q <= ST_MUL_LO;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_sample_q  <= result;
						last_of_run_q <= emit_last;
						phase_q       <= phase_sum;
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							acc_q   <= crs_pkg::ACC_W'(k3_q);
							idx_q   <= crs_pkg::HORNER_K2;
							state_q <= ST_MUL_LO;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// phase is at or above one whenever the block waits for an item
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> phase_q >= crs_pkg::PH_ONE)
		else $error("phase below one while idle");

	// every evaluation runs at a fraction strictly below one
	a_eval_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_LO || state_q == ST_MUL_HI || state_q == ST_EMIT)
		|-> phase_q < crs_pkg::PH_ONE)
		else $error("evaluation with phase at or above one");

	// step in use is always within the clamp range
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_LO || state_q == ST_MUL_HI || state_q == ST_EMIT)
		|-> (step_q >= crs_pkg::RATIO_MIN && step_q <= crs_pkg::RATIO_MAX))
		else $error("step outside clamp range");

	// a new result only comes from the emit or pass-through step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_PASS))
		else $error("output loaded outside emit");

endmodule

`default_nettype wire
